>>> rtl/llc_pkg.sv
`default_nettype none

package llc_pkg;

    // register stages from input to output register
    localparam int NSTG = 39;

    localparam logic [19:0] OUT_MAX       = 20'hFFFFF;
    localparam logic [25:0] LOG2_TEN_Q24  = 26'd55732705;
    localparam logic [22:0] LOG10_TWO_Q24 = 23'd5050445;

    localparam logic OP_LOG_TO_LIN = 1'b0;
    localparam logic OP_LIN_TO_LOG = 1'b1;

    localparam logic [2:0] REG_OPERATION = 3'd0;
    localparam logic [2:0] REG_CHAN_EN   = 3'd1;
    localparam logic [2:0] REG_LIN_REF   = 3'd2;
    localparam logic [2:0] REG_LOG_REF   = 3'd3;
    localparam logic [2:0] REG_NEG_GAMMA = 3'd4;
    localparam logic [2:0] REG_DENSITY   = 3'd5;

    typedef struct packed {
        logic        op;
        logic        chan_en;
        logic [15:0] lin_ref;
        logic [15:0] log_ref;
        logic [15:0] neg_gamma;
        logic [15:0] density;
    } chan_cfg_t;

    // 2^(2^-k) in Q30, k = 0 gives 2^31; evaluated at elaboration only
    function automatic logic [31:0] pow_tab(input int k);
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        t = 64'd1 << 31;
        for (int i = 1; i <= k; i++) begin
            v   = t << 30;
            res = 64'd0;
            for (int b = 31; b >= 0; b--) begin
                bit_v = 64'd1 << (2 * b);
                if (v >= res + bit_v) begin
                    v   = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
            end
            t = res;
        end
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/log_lin_pixel_converter.sv
`default_nettype none

// channel   direction  handshake         payload
// s_        in         s_tvalid/tready   s_tdata: chan0_in, chan1_in, chan2_in
// m_        out        m_tvalid/tready   m_tdata: chan0..2_out, m_tuser: clamp_flags
// apb       in         psel/penable      paddr, pwdata, prdata (registers at 8*i)
//
// one pixel per cycle through 39 register stages while m_tready does not hold the output;
// the 24 stages of the fraction-bit multiply chain set the depth
// aresetn (synchronous) clears the valid pipeline and the registers to defaults
// each stage advances when it or any later stage has a free slot, so bubbles close
// up and input keeps flowing while a result waits on m_tready

module log_lin_pixel_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // chan0_in, chan1_in, chan2_in, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // chan0_out, chan1_out, chan2_out, zero pad
    output logic [2:0]       m_tuser,   // clamp_flags
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic        op_reg;
    logic [2:0]  chan_en_reg;
    logic [47:0] lin_ref_reg;
    logic [47:0] log_ref_reg;
    logic [47:0] neg_gamma_reg;
    logic [47:0] density_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    logic [llc_pkg::NSTG-1:0] en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg        <= llc_pkg::OP_LOG_TO_LIN;
            chan_en_reg   <= 3'b111;
            lin_ref_reg   <= 48'h2E14_2E14_2E14;
            log_ref_reg   <= 48'h6F40_6F40_6F40;
            neg_gamma_reg <= 48'h999A_999A_999A;
            density_reg   <= 48'h20C5_20C5_20C5;
        end else if (wr_en) begin
            case (reg_idx)
                llc_pkg::REG_OPERATION: op_reg        <= pwdata[0];
                llc_pkg::REG_CHAN_EN:   chan_en_reg   <= pwdata[2:0];
                llc_pkg::REG_LIN_REF:   lin_ref_reg   <= pwdata[47:0];
                llc_pkg::REG_LOG_REF:   log_ref_reg   <= pwdata[47:0];
                llc_pkg::REG_NEG_GAMMA: neg_gamma_reg <= pwdata[47:0];
                llc_pkg::REG_DENSITY:   density_reg   <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            llc_pkg::REG_OPERATION: prdata = {63'b0, op_reg};
            llc_pkg::REG_CHAN_EN:   prdata = {61'b0, chan_en_reg};
            llc_pkg::REG_LIN_REF:   prdata = {16'b0, lin_ref_reg};
            llc_pkg::REG_LOG_REF:   prdata = {16'b0, log_ref_reg};
            llc_pkg::REG_NEG_GAMMA: prdata = {16'b0, neg_gamma_reg};
            llc_pkg::REG_DENSITY:   prdata = {16'b0, density_reg};
            default:                prdata = 64'd0;
        endcase
    end

    llc_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .en       (en)
    );

    logic [19:0] y_ch [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        llc_pkg::chan_cfg_t cfg;
        assign cfg.op        = op_reg;
        assign cfg.chan_en   = chan_en_reg[c];
        assign cfg.lin_ref   = lin_ref_reg[16*c +: 16];
        assign cfg.log_ref   = log_ref_reg[16*c +: 16];
        assign cfg.neg_gamma = neg_gamma_reg[16*c +: 16];
        assign cfg.density   = density_reg[16*c +: 16];

        llc_chan u_chan (
            .aclk     (aclk),
            .en       (en),
            .cfg      (cfg),
            .x_in     (s_tdata[20*c +: 20]),
            .y_out    (y_ch[c]),
            .flag_out (m_tuser[c])
        );
    end

    assign m_tdata = {4'b0, y_ch[2], y_ch[1], y_ch[0]};

endmodule

`default_nettype wire

>>> rtl/llc_ctl.sv
`default_nettype none

module llc_ctl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [llc_pkg::NSTG-1:0]      en
);

    localparam int N = llc_pkg::NSTG;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;

    // a stage loads when any slot from it to the output is free or the output drains
    always_comb begin
        for (int k = 0; k < N; k++) begin
            en[k] = m_tready || !(&(vld_reg | ((N'(1) << k) - N'(1))));
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (en[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < N; k++) begin
            if (en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[N-1];

endmodule

`default_nettype wire

>>> rtl/llc_chan.sv
`default_nettype none

module llc_chan (
    input  wire logic                     aclk,
    input  wire logic [llc_pkg::NSTG-1:0] en,
    input  wire llc_pkg::chan_cfg_t       cfg,
    input  wire logic [19:0]              x_in,
    output logic [19:0]                   y_out,
    output logic                          flag_out
);

    function automatic logic [4:0] msb_idx(input logic [19:0] u);
        logic [4:0] m;
        m = 5'd0;
        for (int i = 0; i < 20; i++) begin
            if (u[i]) begin
                m = 5'(i);
            end
        end
        return m;
    endfunction

    // five restoring steps, state is {remainder, dividend/quotient}
    function automatic logic [50:0] a_div5(input logic [50:0] st, input logic [15:0] dvsr);
        logic [15:0] r;
        logic [34:0] q;
        logic [16:0] t;
        r = st[50:35];
        q = st[34:0];
        for (int s = 0; s < 5; s++) begin
            t = {r, q[34]};
            if (t >= {1'b0, dvsr}) begin
                r = 16'(t - {1'b0, dvsr});
                q = {q[33:0], 1'b1};
            end else begin
                r = t[15:0];
                q = {q[33:0], 1'b0};
            end
        end
        return {r, q};
    endfunction

    function automatic logic [45:0] b_div4(input logic [45:0] st, input logic [25:0] dvsr);
        logic [25:0] r;
        logic [19:0] q;
        logic [26:0] t;
        r = st[45:20];
        q = st[19:0];
        for (int s = 0; s < 4; s++) begin
            t = {r, q[19]};
            if (t >= {1'b0, dvsr}) begin
                r = 26'(t - {1'b0, dvsr});
                q = {q[18:0], 1'b1};
            end else begin
                r = t[25:0];
                q = {q[18:0], 1'b0};
            end
        end
        return {r, q};
    endfunction

    // rounded square in Q30, bit 31 set means the square reached 2.0
    function automatic logic [31:0] sq_step(input logic [30:0] w);
        logic [61:0] sq;
        sq = 62'(w) * 62'(w) + (62'd1 << 29);
        return sq[61:30];
    endfunction

    logic [19:0] x_reg   [0:37];
    logic        neg_reg [0:37];

    // log to lin lane
    logic [29:0] mag_reg;
    logic [45:0] prod_reg;
    logic        aovf_reg [2:37];
    logic [15:0] arem_reg [0:7];
    logic [34:0] adv_reg  [0:7];
    logic [28:0] y_reg;
    logic [5:0]  sh_reg   [11:36];
    logic [23:0] f_reg    [11:34];
    logic [31:0] p_reg    [12:35];
    logic [47:0] v_reg;
    logic [19:0] ares_reg;
    logic        asat_reg;

    // lin to log lane
    logic [30:0] wx_reg [0:24];
    logic [30:0] wl_reg [0:24];
    logic [28:0] lx_reg [0:24];
    logic [28:0] ll_reg [0:24];
    logic [28:0] amag_reg;
    logic        bsign_reg [25:27];
    logic [27:0] tm_reg;
    logic [43:0] p1_reg;
    logic [31:0] p2_reg;
    logic [50:0] num_reg;
    logic        bneg_reg [28:37];
    logic        bovf_reg [29:37];
    logic [25:0] brem_reg [0:5];
    logic [19:0] bdv_reg  [0:5];
    logic [19:0] bres_reg [35:37];

    logic [19:0] y_out_reg;
    logic        flag_reg;

    // stage 0
    logic [29:0] x1023;
    logic [30:0] diff0;
    logic [19:0] ux;
    logic [4:0]  mx;
    logic [4:0]  ml;
    logic [25:0] dk;

    assign x1023 = {x_in, 10'b0} - {10'b0, x_in};
    assign diff0 = {1'b0, x1023} - {5'b0, cfg.log_ref, 10'b0};
    assign ux    = (x_in == 20'd0) ? 20'd1 : x_in;
    assign mx    = msb_idx(ux);
    assign ml    = msb_idx({4'b0, cfg.lin_ref});
    assign dk    = {cfg.density, 10'b0} - {10'b0, cfg.density};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg[0]   <= x_in;
            neg_reg[0] <= diff0[30];
            mag_reg    <= diff0[30] ? 30'(31'd0 - diff0) : diff0[29:0];
            wx_reg[0]  <= 31'({11'b0, ux} << (5'd30 - mx));
            wl_reg[0]  <= 31'({15'b0, cfg.lin_ref} << (5'd30 - ml));
            lx_reg[0]  <= {mx, 24'b0};
            ll_reg[0]  <= {ml, 24'b0};
        end
    end

    for (genvar k = 1; k < 38; k++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                x_reg[k]   <= x_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        if (k >= 3) begin : g_aovf
            always_ff @(posedge aclk) begin
                if (en[k]) aovf_reg[k] <= aovf_reg[k-1];
            end
        end
        if (k >= 12 && k <= 36) begin : g_sh
            always_ff @(posedge aclk) begin
                if (en[k]) sh_reg[k] <= sh_reg[k-1];
            end
        end
        if (k >= 12 && k <= 34) begin : g_f
            always_ff @(posedge aclk) begin
                if (en[k]) f_reg[k] <= f_reg[k-1];
            end
        end
        if (k >= 26 && k <= 27) begin : g_bsign
            always_ff @(posedge aclk) begin
                if (en[k]) bsign_reg[k] <= bsign_reg[k-1];
            end
        end
        if (k >= 29) begin : g_bneg
            always_ff @(posedge aclk) begin
                if (en[k]) bneg_reg[k] <= bneg_reg[k-1];
            end
        end
        if (k >= 30) begin : g_bovf
            always_ff @(posedge aclk) begin
                if (en[k]) bovf_reg[k] <= bovf_reg[k-1];
            end
        end
        if (k >= 36) begin : g_bres
            always_ff @(posedge aclk) begin
                if (en[k]) bres_reg[k] <= bres_reg[k-1];
            end
        end
    end

    // log to lin: scale by density, then divide by gamma
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            prod_reg <= 46'(mag_reg) * 46'(cfg.density);
        end
        if (en[2]) begin
            // exponent of eight or more decades
            aovf_reg[2] <= prod_reg >= {5'b0, cfg.neg_gamma, 25'b0};
            arem_reg[0] <= prod_reg[40:25];
            adv_reg[0]  <= {prod_reg[24:0], 10'b0};
        end
    end

    for (genvar g = 0; g < 7; g++) begin : g_adiv
        always_ff @(posedge aclk) begin
            if (en[3+g]) begin
                {arem_reg[g+1], adv_reg[g+1]} <=
                    a_div5({arem_reg[g], adv_reg[g]}, cfg.neg_gamma);
            end
        end
    end

    logic [61:0] ymul;
    logic [4:0]  yi;
    logic [23:0] yf;
    logic        fnz;

    assign ymul = 62'(adv_reg[7]) * 62'(llc_pkg::LOG2_TEN_Q24) + (62'd1 << 31);
    assign yi   = y_reg[28:24];
    assign yf   = y_reg[23:0];
    assign fnz  = |yf;

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            y_reg <= ymul[60:32];
        end
        if (en[11]) begin
            // negative exponent: floor goes one further down, fraction mirrors
            sh_reg[11] <= neg_reg[10] ? 6'd30 + {1'b0, yi} + {5'b0, fnz}
                                      : 6'd30 - {1'b0, yi};
            f_reg[11]  <= neg_reg[10] ? (24'd0 - yf) : yf;
        end
    end

    for (genvar k = 1; k <= 24; k++) begin : g_pow
        localparam logic [31:0] TK = llc_pkg::pow_tab(k);
        logic [31:0] pin;
        logic [63:0] pm;
        if (k == 1) begin : g_first
            assign pin = 32'h4000_0000;
        end else begin : g_rest
            assign pin = p_reg[10+k];
        end
        assign pm = 64'(pin) * 64'(TK) + (64'd1 << 29);
        always_ff @(posedge aclk) begin
            if (en[11+k]) begin
                p_reg[11+k] <= f_reg[10+k][24-k] ? pm[61:30] : pin;
            end
        end
    end

    logic [48:0] vr;
    assign vr = ({1'b0, v_reg} + (49'd1 << (sh_reg[36] - 6'd1))) >> sh_reg[36];

    always_ff @(posedge aclk) begin
        if (en[36]) begin
            v_reg <= 48'(cfg.lin_ref) * 48'(p_reg[35]);
        end
        if (en[37]) begin
            if (sh_reg[36] >= 6'd48) begin
                ares_reg <= 20'd0;
                asat_reg <= 1'b0;
            end else if (vr > 49'(llc_pkg::OUT_MAX)) begin
                ares_reg <= llc_pkg::OUT_MAX;
                asat_reg <= 1'b1;
            end else begin
                ares_reg <= vr[19:0];
                asat_reg <= 1'b0;
            end
        end
    end

    // lin to log: log2 by repeated squaring, one fraction bit per stage
    for (genvar j = 1; j <= 24; j++) begin : g_log
        logic [31:0] rx;
        logic [31:0] rl;
        assign rx = sq_step(wx_reg[j-1]);
        assign rl = sq_step(wl_reg[j-1]);
        always_ff @(posedge aclk) begin
            if (en[j]) begin
                wx_reg[j] <= rx[31] ? rx[31:1] : rx[30:0];
                wl_reg[j] <= rl[31] ? rl[31:1] : rl[30:0];
                lx_reg[j] <= lx_reg[j-1] | ({28'b0, rx[31]} << (24 - j));
                ll_reg[j] <= ll_reg[j-1] | ({28'b0, rl[31]} << (24 - j));
            end
        end
    end

    logic [29:0] adiff;
    logic [52:0] tmul;
    logic [49:0] num_hi;
    logic [49:0] num_lo;
    logic [51:0] np;
    logic [43:0] nq;

    assign adiff  = {1'b0, lx_reg[24]} - {1'b0, ll_reg[24]};
    assign tmul   = 53'(amag_reg) * 53'(llc_pkg::LOG10_TWO_Q24) + (53'd1 << 23);
    assign num_hi = {p2_reg, 18'b0};
    assign num_lo = {p1_reg, 6'b0};
    assign np     = 52'(num_reg) + 52'({dk, 7'b0});
    assign nq     = np[51:8];

    always_ff @(posedge aclk) begin
        if (en[25]) begin
            bsign_reg[25] <= adiff[29];
            amag_reg      <= adiff[29] ? 29'(30'd0 - adiff) : adiff[28:0];
        end
        if (en[26]) begin
            tm_reg <= tmul[51:24];
        end
        if (en[27]) begin
            p1_reg <= 44'(tm_reg) * 44'(cfg.neg_gamma);
            p2_reg <= 32'(cfg.log_ref) * 32'(cfg.density);
        end
        if (en[28]) begin
            if (bsign_reg[27]) begin
                bneg_reg[28] <= num_lo > num_hi;
                num_reg      <= 51'(num_hi - num_lo);
            end else begin
                bneg_reg[28] <= 1'b0;
                num_reg      <= 51'(num_hi) + 51'(num_lo);
            end
        end
        if (en[29]) begin
            // rounding half the divisor in, low eight divisor zeros taken out
            bovf_reg[29] <= 46'(nq) >= {dk, 20'b0};
            brem_reg[0]  <= {2'b0, nq[43:20]};
            bdv_reg[0]   <= nq[19:0];
        end
    end

    for (genvar g = 0; g < 5; g++) begin : g_bdiv
        always_ff @(posedge aclk) begin
            if (en[30+g]) begin
                {brem_reg[g+1], bdv_reg[g+1]} <= b_div4({brem_reg[g], bdv_reg[g]}, dk);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[35]) begin
            bres_reg[35] <= bdv_reg[5];
        end
    end

    // output stage
    logic [19:0] y_next;
    logic        flag_next;

    always_comb begin
        y_next    = ares_reg;
        flag_next = asat_reg;
        if (!cfg.chan_en) begin
            y_next    = x_reg[37];
            flag_next = 1'b0;
        end else if (cfg.op == llc_pkg::OP_LOG_TO_LIN) begin
            if (cfg.neg_gamma == 16'd0) begin
                y_next    = llc_pkg::OUT_MAX;
                flag_next = 1'b1;
            end else if (cfg.lin_ref == 16'd0) begin
                y_next    = 20'd0;
                flag_next = 1'b0;
            end else if (aovf_reg[37]) begin
                y_next    = neg_reg[37] ? 20'd0 : llc_pkg::OUT_MAX;
                flag_next = !neg_reg[37];
            end
        end else begin
            if (cfg.lin_ref == 16'd0 || cfg.density == 16'd0) begin
                y_next    = llc_pkg::OUT_MAX;
                flag_next = 1'b1;
            end else if (bneg_reg[37]) begin
                y_next    = 20'd0;
                flag_next = 1'b1;
            end else if (bovf_reg[37]) begin
                y_next    = llc_pkg::OUT_MAX;
                flag_next = 1'b1;
            end else begin
                y_next    = bres_reg[37];
                flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[38]) begin
            y_out_reg <= y_next;
            flag_reg  <= flag_next;
        end
    end

    assign y_out    = y_out_reg;
    assign flag_out = flag_reg;

endmodule

`default_nettype wire
